// File: sv/chunked_datagram_reassembly_top_defines.svh
// Assertion helpers for the reassembly checker.
`ifndef CHUNKED_DATAGRAM_REASSEMBLY_TOP_DEFINES_SVH
`define CHUNKED_DATAGRAM_REASSEMBLY_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define CDR_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define CDR_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/cdr_pkg.sv
`default_nettype none
package cdr_pkg;

    localparam int PCNT_W      = 7;
    localparam int OUT_CHUNK_W = 6;
    localparam int LEN_W       = 16;

    localparam logic [15:0] HEADER_BYTES = 16'd18;
    localparam logic [31:0] PING_LIMIT   = 32'd2;

    typedef enum logic [3:0] {
        ST_SHORT    = 4'd0,
        ST_MISMATCH = 4'd1,
        ST_PING     = 4'd2,
        ST_EMPTY    = 4'd3,
        ST_ZERO     = 4'd4,
        ST_RANGE    = 4'd5,
        ST_STORED   = 4'd6,
        ST_DUP      = 4'd7,
        ST_DELIVER  = 4'd8,
        ST_TOOMANY  = 4'd9
    } status_t;

endpackage
`default_nettype wire

// File: sv/cdr_if.sv
`default_nettype none
interface cdr_hdr_if;
    logic        valid;
    logic        ready;
    logic [63:0] packet_id;
    logic [15:0] chunk_index;
    logic [15:0] total_chunks;
    logic [15:0] declared_length;
    logic [31:0] packet_type;
    logic [15:0] datagram_bytes;

    modport source (output valid, packet_id, chunk_index, total_chunks,
                    declared_length, packet_type, datagram_bytes, input ready);
    modport sink   (input valid, packet_id, chunk_index, total_chunks,
                    declared_length, packet_type, datagram_bytes, output ready);
endinterface

interface cdr_res_if;
    import cdr_pkg::*;
    logic        valid;
    logic        ready;
    status_t     status;
    logic [31:0] out_type;
    logic [63:0] out_id;
    logic [5:0]  out_chunk;
    logic [15:0] out_length;
    logic        last;

    modport source (output valid, status, out_type, out_id, out_chunk, out_length,
                    last, input ready);
    modport sink   (input valid, status, out_type, out_id, out_chunk, out_length,
                    last, output ready);
endinterface
`default_nettype wire

// File: sv/cdr_len_ram.sv
`default_nettype none
module cdr_len_ram
    import cdr_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [LEN_W-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [LEN_W-1:0] rdata
);

    logic [LEN_W-1:0] mem [DEPTH];
    logic [LEN_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read: rdata shows the word addressed in the previous cycle.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: sv/chunked_datagram_reassembly_top.sv
// A header word's result is registered from S_EVAL, which holds until the output register is free.
// A new header word is taken only in S_IDLE, after the previous one has been resolved.
// A completing chunk of an N-chunk packet delivers each chunk by a RAM read, then an output state.
// The single read port of the chunk length RAM sets the delivery pace.
// Reset: pending packet idle, chunk bitmap cleared at once; length RAM holds garbage until written.
`default_nettype none
module chunked_datagram_reassembly_top
    import cdr_pkg::*;
#(
    parameter int MAX_CHUNKS = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    cdr_hdr_if.sink    hdr,
    cdr_res_if.source  res
);

    localparam int IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DRD,
        S_DWR
    } state_t;

    state_t state_reg, state_next;

    // Latched header word (payload, no reset).
    logic [63:0] id_reg,    id_next;
    logic [15:0] idx_reg,   idx_next;
    logic [15:0] cnt_reg,   cnt_next;
    logic [15:0] len_reg,   len_next;
    logic [31:0] ty_reg,    ty_next;
    logic [15:0] bytes_reg, bytes_next;

    // Pending packet bookkeeping.
    logic [63:0]           pend_id_reg,  pend_id_next;
    logic [PCNT_W-1:0]     pend_cnt_reg, pend_cnt_next;
    logic [31:0]           pend_ty_reg,  pend_ty_next;
    logic [PCNT_W-1:0]     rcv_reg,      rcv_next;
    logic [MAX_CHUNKS-1:0] present_reg,  present_next;
    logic [IDX_W-1:0]      dlv_reg,      dlv_next;

    // Output register.
    logic                   out_valid_reg, out_valid_next;
    status_t                status_reg,    status_next;
    logic [31:0]            otype_reg,     otype_next;
    logic [63:0]            oid_reg,       oid_next;
    logic [OUT_CHUNK_W-1:0] ochunk_reg,    ochunk_next;
    logic [LEN_W-1:0]       olen_reg,      olen_next;
    logic                   olast_reg,     olast_next;

    // RAM side.
    logic             ram_we;
    logic [IDX_W-1:0] ram_raddr;
    logic [LEN_W-1:0] ram_rdata;
    logic [IDX_W-1:0] slot;

    // Evaluation helpers.
    logic                  out_free;
    logic                  restart;
    logic [MAX_CHUNKS-1:0] present_base;
    logic [PCNT_W-1:0]     rcv_base;
    logic [PCNT_W-1:0]     rcv_inc;
    logic                  dlv_last;

    assign slot     = idx_reg[IDX_W-1:0];
    assign out_free = !out_valid_reg || res.ready;

    // Restart the pending packet on idle, or on a change of id, count or type.
    assign restart = (pend_id_reg == 64'd0) || (pend_id_reg != id_reg)
                   || ({{(16-PCNT_W){1'b0}}, pend_cnt_reg} != cnt_reg)
                   || (pend_ty_reg != ty_reg);
    assign present_base = restart ? '0 : present_reg;
    assign rcv_base     = restart ? '0 : rcv_reg;
    assign rcv_inc      = rcv_base + PCNT_W'(1);
    assign dlv_last     = ((PCNT_W'(dlv_reg) + PCNT_W'(1)) == pend_cnt_reg);

    // Point the single read port at whatever the current state needs next cycle.
    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  ram_raddr = hdr.chunk_index[IDX_W-1:0];
            S_EVAL:  ram_raddr = slot;
            S_DRD,
            S_DWR:   ram_raddr = dlv_reg;
            default: ram_raddr = dlv_reg;
        endcase
    end

    cdr_len_ram #(
        .DEPTH (MAX_CHUNKS),
        .AW    (IDX_W)
    ) u_len_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot),
        .wdata (len_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        id_next       = id_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        len_next      = len_reg;
        ty_next       = ty_reg;
        bytes_next    = bytes_reg;
        pend_id_next  = pend_id_reg;
        pend_cnt_next = pend_cnt_reg;
        pend_ty_next  = pend_ty_reg;
        rcv_next      = rcv_reg;
        present_next  = present_reg;
        dlv_next      = dlv_reg;
        ram_we        = 1'b0;

        // Drain the output register when taken; a load below overrides.
        out_valid_next = out_valid_reg && !res.ready;
        status_next    = status_reg;
        otype_next     = otype_reg;
        oid_next       = oid_reg;
        ochunk_next    = ochunk_reg;
        olen_next      = olen_reg;
        olast_next     = olast_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (hdr.valid)
                begin
                    id_next    = hdr.packet_id;
                    idx_next   = hdr.chunk_index;
                    cnt_next   = hdr.total_chunks;
                    len_next   = hdr.declared_length;
                    ty_next    = hdr.packet_type;
                    bytes_next = hdr.datagram_bytes;
                    state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                // Hold the word here until the output register can take a result.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    otype_next     = '0;
                    oid_next       = id_reg;
                    ochunk_next    = '0;
                    olen_next      = '0;
                    olast_next     = 1'b1;
                    state_next     = S_IDLE;

                    priority if (bytes_reg < HEADER_BYTES)
                    begin
                        status_next = ST_SHORT;
                    end
                    else if (len_reg > (bytes_reg - HEADER_BYTES))
                    begin
                        status_next = ST_MISMATCH;
                    end
                    else if (ty_reg < PING_LIMIT)
                    begin
                        status_next = ST_PING;
                        otype_next  = ty_reg;
                    end
                    else if (len_reg == 16'd0)
                    begin
                        status_next = ST_EMPTY;
                        otype_next  = ty_reg;
                    end
                    else if (cnt_reg == 16'd0)
                    begin
                        status_next = ST_ZERO;
                    end
                    else if ({16'd0, cnt_reg} > 32'(MAX_CHUNKS))
                    begin
                        // Abandon the pending packet.
                        status_next   = ST_TOOMANY;
                        pend_id_next  = '0;
                        pend_cnt_next = '0;
                        pend_ty_next  = '0;
                        rcv_next      = '0;
                        present_next  = '0;
                    end
                    else
                    begin
                        pend_id_next  = id_reg;
                        pend_cnt_next = cnt_reg[PCNT_W-1:0];
                        pend_ty_next  = ty_reg;
                        rcv_next      = rcv_base;
                        present_next  = present_base;

                        priority if (idx_reg >= cnt_reg)
                        begin
                            status_next = ST_RANGE;
                        end
                        else if (present_base[slot])
                        begin
                            // Length read was launched at acceptance.
                            status_next = ST_DUP;
                            ochunk_next = OUT_CHUNK_W'(slot);
                            olen_next   = ram_rdata;
                        end
                        else
                        begin
                            ram_we             = 1'b1;
                            present_next[slot] = 1'b1;
                            rcv_next           = rcv_inc;
                            if ({{(16-PCNT_W){1'b0}}, rcv_inc} < cnt_reg)
                            begin
                                status_next = ST_STORED;
                                ochunk_next = OUT_CHUNK_W'(slot);
                                olen_next   = len_reg;
                            end
                            else
                            begin
                                // Complete: walk the slots in index order.
                                out_valid_next = out_valid_reg && !res.ready;
                                dlv_next       = '0;
                                state_next     = S_DRD;
                            end
                        end
                    end
                end
            end

            S_DRD:
            begin
                state_next = S_DWR;
            end

            S_DWR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_DELIVER;
                    otype_next     = pend_ty_reg;
                    oid_next       = pend_id_reg;
                    ochunk_next    = OUT_CHUNK_W'(dlv_reg);
                    olen_next      = ram_rdata;
                    olast_next     = dlv_last;
                    if (dlv_last)
                    begin
                        pend_id_next  = '0;
                        pend_cnt_next = '0;
                        pend_ty_next  = '0;
                        rcv_next      = '0;
                        present_next  = '0;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        dlv_next   = dlv_reg + IDX_W'(1);
                        state_next = S_DRD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_id_reg   <= '0;
            pend_cnt_reg  <= '0;
            pend_ty_reg   <= '0;
            rcv_reg       <= '0;
            present_reg   <= '0;
            dlv_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_id_reg   <= pend_id_next;
            pend_cnt_reg  <= pend_cnt_next;
            pend_ty_reg   <= pend_ty_next;
            rcv_reg       <= rcv_next;
            present_reg   <= present_next;
            dlv_reg       <= dlv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg     <= id_next;
        idx_reg    <= idx_next;
        cnt_reg    <= cnt_next;
        len_reg    <= len_next;
        ty_reg     <= ty_next;
        bytes_reg  <= bytes_next;
        status_reg <= status_next;
        otype_reg  <= otype_next;
        oid_reg    <= oid_next;
        ochunk_reg <= ochunk_next;
        olen_reg   <= olen_next;
        olast_reg  <= olast_next;
    end

    assign hdr.ready      = (state_reg == S_IDLE);
    assign res.valid      = out_valid_reg;
    assign res.status     = status_reg;
    assign res.out_type   = otype_reg;
    assign res.out_id     = oid_reg;
    assign res.out_chunk  = ochunk_reg;
    assign res.out_length = olen_reg;
    assign res.last       = olast_reg;

endmodule
`default_nettype wire

// File: sv/cdr_chk.sv
`default_nettype none
`include "chunked_datagram_reassembly_top_defines.svh"
module cdr_chk
    import cdr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        hdr_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [3:0]  res_status,
    input logic [31:0] res_type,
    input logic        res_last
);

    // Stalled result word holds.
    `CDR_CHECK_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_status) && $stable(res_last), "result word changed while stalled")

    // Only delivery emits more than one word per header.
    `CDR_CHECK(a_multi_is_deliver, res_valid && !res_last, res_status == ST_DELIVER, "non-final word outside delivery")

    // No header is taken in the middle of a delivery run.
    `CDR_CHECK(a_no_accept_mid_run, res_valid && res_ready && !res_last, !hdr_ready, "header accepted during delivery")

    // Delivered packets never carry a ping type.
    `CDR_CHECK(a_deliver_type, res_valid && res_status == ST_DELIVER, res_type > 32'd1, "delivery with ping type")

endmodule

bind chunked_datagram_reassembly_top cdr_chk u_cdr_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .hdr_ready  (hdr.ready),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_status (res.status),
    .res_type   (res.out_type),
    .res_last   (res.last)
);
`default_nettype wire

// File: dv/tb.sv
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cdr_pkg::*;

    localparam int    CHUNK_SLOTS  = 64;
    localparam int    IDLE_PCT     = 6;
    localparam int    WORD_TARGET  = 470;
    // No idling on either side while header words CALM_FROM up to CALM_TO go through.
    localparam int    CALM_FROM    = 150;
    localparam int    CALM_TO      = 260;
    // Receiver holds off once, long enough to back the block up into its input.
    localparam int    HOLD_AT      = 330;
    localparam int    HOLD_CYCLES  = 300;
    // Settling wait; a delivery spends a RAM read and an output state on each chunk.
    localparam int    DRAIN_CYCLES = 200;
    localparam longint LIMIT_NS    = 64'd20_000_000;

    typedef struct packed {
        logic [63:0] packet_id;
        logic [15:0] chunk_index;
        logic [15:0] total_chunks;
        logic [15:0] declared_length;
        logic [31:0] packet_type;
        logic [15:0] datagram_bytes;
    } header_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] out_type;
        logic [63:0] out_id;
        logic [5:0]  out_chunk;
        logic [15:0] out_length;
        logic        last;
    } result_t;

    // Tracks the one pending packet the way the block should and queues the
    // results each accepted header word must produce.
    class reassembly_scoreboard;
        logic [63:0] pend_id;
        int unsigned pend_count;
        logic [31:0] pend_type;
        int unsigned got_count;
        bit          slot_full[CHUNK_SLOTS];
        logic [15:0] slot_len[CHUNK_SLOTS];
        result_t     expected_q[$];
        int          failures;
        int          reported;
        int          results_seen;
        int          status_hits[16];
        int          completions;

        function new();
            drop_pending();
            failures     = 0;
            reported     = 0;
            results_seen = 0;
            completions  = 0;
            foreach (status_hits[i])
            begin
                status_hits[i] = 0;
            end
        endfunction

        function void drop_pending();
            pend_id    = '0;
            pend_count = 0;
            pend_type  = '0;
            got_count  = 0;
            foreach (slot_full[i])
            begin
                slot_full[i] = 1'b0;
            end
        endfunction

        function void expect_result(status_t st, logic [31:0] ty, logic [63:0] id,
                                    logic [5:0] chunk, logic [15:0] len, logic fin);
            result_t r;
            r.status     = st;
            r.out_type   = ty;
            r.out_id     = id;
            r.out_chunk  = chunk;
            r.out_length = len;
            r.last       = fin;
            expected_q.push_back(r);
            status_hits[int'(st)]++;
        endfunction

        function void note_header(header_t h);
            int unsigned room;
            int unsigned idx;
            int unsigned cnt;
            room = (h.datagram_bytes >= HEADER_BYTES) ? h.datagram_bytes - HEADER_BYTES : 0;
            idx  = h.chunk_index;
            cnt  = h.total_chunks;
            if (h.datagram_bytes < HEADER_BYTES)
            begin
                expect_result(ST_SHORT, '0, h.packet_id, '0, '0, 1'b1);
            end
            else if (h.declared_length > room)
            begin
                expect_result(ST_MISMATCH, '0, h.packet_id, '0, '0, 1'b1);
            end
            else if (h.packet_type < PING_LIMIT)
            begin
                expect_result(ST_PING, h.packet_type, h.packet_id, '0, '0, 1'b1);
            end
            else if (h.declared_length == 0)
            begin
                expect_result(ST_EMPTY, h.packet_type, h.packet_id, '0, '0, 1'b1);
            end
            else if (cnt == 0)
            begin
                expect_result(ST_ZERO, '0, h.packet_id, '0, '0, 1'b1);
            end
            else if (cnt > CHUNK_SLOTS)
            begin
                drop_pending();
                expect_result(ST_TOOMANY, '0, h.packet_id, '0, '0, 1'b1);
            end
            else
            begin
                if (pend_id == 0 || pend_id != h.packet_id || pend_count != cnt ||
                    pend_type != h.packet_type)
                begin
                    drop_pending();
                    pend_id    = h.packet_id;
                    pend_count = cnt;
                    pend_type  = h.packet_type;
                end
                if (idx >= pend_count)
                begin
                    expect_result(ST_RANGE, '0, h.packet_id, '0, '0, 1'b1);
                end
                else if (slot_full[idx])
                begin
                    expect_result(ST_DUP, '0, h.packet_id, 6'(idx), slot_len[idx], 1'b1);
                end
                else
                begin
                    slot_full[idx] = 1'b1;
                    slot_len[idx]  = h.declared_length;
                    got_count++;
                    if (got_count < pend_count)
                    begin
                        expect_result(ST_STORED, '0, h.packet_id, 6'(idx),
                                      h.declared_length, 1'b1);
                    end
                    else
                    begin
                        for (int i = 0; i < pend_count; i++)
                        begin
                            expect_result(ST_DELIVER, pend_type, pend_id, 6'(i),
                                          slot_len[i], i == pend_count - 1);
                        end
                        completions++;
                        drop_pending();
                    end
                end
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                failures++;
                if (reported < 10)
                begin
                    $display("unexpected result: status %0d type %h id %h chunk %0d len %0d last %0d",
                             got.status, got.out_type, got.out_id, got.out_chunk,
                             got.out_length, got.last);
                end
                reported++;
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status || got.out_type !== want.out_type ||
                got.out_id !== want.out_id || got.out_chunk !== want.out_chunk ||
                got.out_length !== want.out_length || got.last !== want.last)
            begin
                failures++;
                if (reported < 10)
                begin
                    $display("result %0d mismatch at %0t", results_seen, $realtime);
                    $display("  want: status %0d type %h id %h chunk %0d len %0d last %0d",
                             want.status, want.out_type, want.out_id, want.out_chunk,
                             want.out_length, want.last);
                    $display("  got:  status %0d type %h id %h chunk %0d len %0d last %0d",
                             got.status, got.out_type, got.out_id, got.out_chunk,
                             got.out_length, got.last);
                end
                reported++;
            end
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    cdr_hdr_if hdr ();
    cdr_res_if res ();

    chunked_datagram_reassembly_top #(
        .MAX_CHUNKS (CHUNK_SLOTS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .hdr   (hdr),
        .res   (res)
    );

    reassembly_scoreboard sb = new();

    int words_sent = 0;
    bit calm       = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: far beyond the slowest legal run.
    initial
    begin
        #(LIMIT_NS);
        $display("tb NOT OK");
        $finish;
    end

    // Watch both handshakes at the clock edge, using the values that the
    // edge itself sees; note every accepted header word before checking
    // results of the same edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hdr.valid && hdr.ready)
            begin
                sb.note_header(header_t'{hdr.packet_id, hdr.chunk_index, hdr.total_chunks,
                                         hdr.declared_length, hdr.packet_type,
                                         hdr.datagram_bytes});
            end
            if (res.valid && res.ready)
            begin
                sb.check_result(result_t'{res.status, res.out_type, res.out_id,
                                          res.out_chunk, res.out_length, res.last});
            end
        end
    end

    // Result side: stall at random, drop stalls during the calm stretch, and
    // once hold ready low for a long run so the block fills up and pushes
    // back on its header input.
    initial
    begin
        bit held;
        held = 1'b0;
        res.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && words_sent >= HOLD_AT)
            begin
                res.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                held = 1'b1;
            end
            else
            begin
                res.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Offer one header word; hold it until the block takes it. Valid stays
    // high afterwards so back-to-back words need no second assignment.
    task automatic send_word(input header_t w);
        calm = (words_sent >= CALM_FROM && words_sent < CALM_TO);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            hdr.valid <= 1'b0;
            @(posedge clk);
        end
        hdr.valid           <= 1'b1;
        hdr.packet_id       <= w.packet_id;
        hdr.chunk_index     <= w.chunk_index;
        hdr.total_chunks    <= w.total_chunks;
        hdr.declared_length <= w.declared_length;
        hdr.packet_type     <= w.packet_type;
        hdr.datagram_bytes  <= w.datagram_bytes;
        @(posedge clk);
        while (!hdr.ready)
            @(posedge clk);
        words_sent++;
    endtask

    // Build a well-formed chunk word: the datagram always has room for the payload.
    function automatic header_t chunk_word(logic [63:0] id, int idx, int cnt,
                                           logic [31:0] ty);
        int len;
        int b;
        len = ($urandom_range(99) < 5) ? $urandom_range(1, 65517) : $urandom_range(1, 1472);
        b   = 18 + len + $urandom_range(0, 3);
        if (b > 65535)
            b = 65535;
        return header_t'{id, 16'(idx), 16'(cnt), 16'(len), ty, 16'(b)};
    endfunction

    // Words that fall out before the pending packet is touched, plus fully
    // random words and oversized counts that may restart or abandon it.
    task automatic send_noise();
        header_t w;
        int      room;
        w = header_t'{{$urandom, $urandom}, 16'($urandom), 16'($urandom), 16'($urandom),
                      32'($urandom), 16'($urandom)};
        if (w.datagram_bytes < 18)
            w.datagram_bytes = 16'($urandom_range(18, 65535));
        room = w.datagram_bytes - 18;
        case ($urandom_range(0, 6))
            0: w.datagram_bytes = 16'($urandom);
            1: w.datagram_bytes = 16'($urandom_range(0, 17));
            2:
            begin
                if (room == 65517)
                    w.datagram_bytes = 16'($urandom_range(18, 65534));
                room = w.datagram_bytes - 18;
                w.declared_length = 16'($urandom_range(room + 1, 65535));
            end
            3:
            begin
                w.packet_type     = 32'($urandom_range(0, 1));
                w.declared_length = 16'($urandom_range(0, room));
            end
            4:
            begin
                w.declared_length = '0;
                w.packet_type     = 32'($urandom_range(2, 32'hFFFF_FFFF));
            end
            5:
            begin
                w.total_chunks    = '0;
                w.declared_length = 16'($urandom_range(1, room > 0 ? room : 1));
                w.packet_type     = 32'($urandom_range(2, 32'hFFFF_FFFF));
                w.datagram_bytes  = (room == 0) ? 16'd19 : w.datagram_bytes;
            end
            default:
            begin
                w.total_chunks    = 16'($urandom_range(65, 65535));
                w.declared_length = 16'($urandom_range(1, room > 0 ? room : 1));
                w.packet_type     = 32'($urandom_range(2, 32'hFFFF_FFFF));
                w.datagram_bytes  = (room == 0) ? 16'd19 : w.datagram_bytes;
            end
        endcase
        send_word(w);
    endtask

    // Send every chunk of one packet in shuffled order with some duplicates and
    // out-of-range indexes. Unless clean, mix in noise words and sometimes break off.
    task automatic send_packet(input logic [63:0] id, input int cnt, input logic [31:0] ty,
                               input bit clean);
        int order[CHUNK_SLOTS];
        int j;
        int tmp;
        header_t w;
        for (int k = 0; k < cnt; k++)
            order[k] = k;
        for (int k = cnt - 1; k > 0; k--)
        begin
            j        = $urandom_range(0, k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (int k = 0; k < cnt; k++)
        begin
            if (!clean && $urandom_range(99) < 6)
                send_noise();
            if (k > 0 && $urandom_range(99) < 8)
                send_word(chunk_word(id, order[$urandom_range(0, k - 1)], cnt, ty));
            if ($urandom_range(99) < 4)
            begin
                w = chunk_word(id, 0, cnt, ty);
                w.chunk_index = 16'($urandom_range(cnt, 65535));
                send_word(w);
            end
            if (!clean && $urandom_range(99) < 3)
                return;
            send_word(chunk_word(id, order[k], cnt, ty));
        end
    endtask

    initial
    begin
        logic [63:0] id;
        logic [63:0] prev_id;
        logic [31:0] ty;
        int          cnt;
        int          pick;
        bit          first;

        rst_n               = 1'b0;
        hdr.valid           <= 1'b0;
        hdr.packet_id       <= '0;
        hdr.chunk_index     <= '0;
        hdr.total_chunks    <= '0;
        hdr.declared_length <= '0;
        hdr.packet_type     <= '0;
        hdr.datagram_bytes  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: drop paths, one packet walked through restart, duplicate, range,
        // abandon and completion, id-zero packets, a type change and an all-ones id.
        send_word(header_t'{64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 16'd1, 16'd0, 32'd2, 16'd0});
        send_word(header_t'{64'd5, 16'd0, 16'd1, 16'd0, 32'd2, 16'd17});
        send_word(header_t'{64'd5, 16'd0, 16'd1, 16'd1, 32'd2, 16'd18});
        send_word(header_t'{64'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF});
        send_word(header_t'{64'd6, 16'd0, 16'd1, 16'd5, 32'd0, 16'd30});
        send_word(header_t'{64'd6, 16'd0, 16'd1, 16'd0, 32'd1, 16'd18});
        send_word(header_t'{64'd7, 16'd0, 16'd1, 16'd0, 32'hFFFF_FFFF, 16'd18});
        send_word(header_t'{64'd7, 16'd0, 16'd0, 16'd4, 32'd2, 16'd22});
        send_word(header_t'{64'd7, 16'd0, 16'd65, 16'd4, 32'd2, 16'd22});
        send_word(header_t'{64'd7, 16'd0, 16'hFFFF, 16'd4, 32'd2, 16'd22});
        send_word(header_t'{64'hA5A5, 16'd0, 16'd3, 16'd100, 32'd2, 16'd118});
        send_word(header_t'{64'hA5A5, 16'd0, 16'd3, 16'd200, 32'd2, 16'd218});
        send_word(header_t'{64'hA5A5, 16'd3, 16'd3, 16'd10, 32'd2, 16'd28});
        send_word(header_t'{64'hA5A5, 16'hFFFF, 16'd3, 16'd10, 32'd2, 16'd28});
        send_word(header_t'{64'hA5A5, 16'd0, 16'd65, 16'd10, 32'd2, 16'd28});
        send_word(header_t'{64'hA5A5, 16'd1, 16'd3, 16'd11, 32'd2, 16'd29});
        send_word(header_t'{64'hA5A5, 16'd2, 16'd3, 16'd12, 32'd2, 16'd30});
        send_word(header_t'{64'hA5A5, 16'd0, 16'd3, 16'd65517, 32'd2, 16'hFFFF});
        send_word(header_t'{64'd0, 16'd0, 16'd1, 16'd9, 32'd3, 16'd27});
        send_word(header_t'{64'd0, 16'd0, 16'd2, 16'd9, 32'd3, 16'd27});
        send_word(header_t'{64'd0, 16'd1, 16'd2, 16'd9, 32'd3, 16'd27});
        send_word(header_t'{64'hBEEF, 16'd1, 16'd2, 16'd8, 32'd40, 16'd26});
        send_word(header_t'{64'hBEEF, 16'd0, 16'd2, 16'd8, 32'd41, 16'd26});
        send_word(header_t'{64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 16'd1, 16'd65517,
                            32'hFFFF_FFFF, 16'hFFFF});

        // Random: mostly whole packets with random content, the rest noise.
        // Open with one clean full-size packet so every slot gets delivered.
        first   = 1'b1;
        prev_id = '0;
        while (words_sent < WORD_TARGET)
        begin
            if (!first && $urandom_range(99) >= 80)
            begin
                send_noise();
            end
            else
            begin
                pick = $urandom_range(99);
                if (first)
                    cnt = CHUNK_SLOTS;
                else if (pick < 70)
                    cnt = $urandom_range(1, 6);
                else if (pick < 95)
                    cnt = $urandom_range(7, 20);
                else
                    cnt = $urandom_range(40, CHUNK_SLOTS);
                pick = $urandom_range(99);
                if (pick < 5)
                    id = '0;
                else if (pick < 15)
                    id = prev_id;
                else
                    id = {$urandom, $urandom};
                ty = $urandom;
                if (ty < 2)
                    ty = 32'hFFFF_FFFF;
                send_packet(id, cnt, ty, first);
                prev_id = id;
                first   = 1'b0;
            end
        end
        hdr.valid <= 1'b0;

        // Drain: wait for every queued result, then let the pipeline settle.
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.outstanding() != 0)
            sb.failures++;

        $display("covered %0d header words and %0d results: %0d packets completed,",
                 words_sent, sb.results_seen, sb.completions);
        $display("  %0d stored, %0d duplicates, %0d out of range, %0d oversized, %0d dropped early",
                 sb.status_hits[ST_STORED], sb.status_hits[ST_DUP],
                 sb.status_hits[ST_RANGE], sb.status_hits[ST_TOOMANY],
                 sb.status_hits[ST_SHORT] + sb.status_hits[ST_MISMATCH] +
                 sb.status_hits[ST_PING] + sb.status_hits[ST_EMPTY] +
                 sb.status_hits[ST_ZERO]);
        if (sb.failures == 0)
        begin
            $display("tb OK");
        end
        else
        begin
            $display("%0d failures", sb.failures);
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
`default_nettype wire
